### rtl/ttui_pkg.sv
// Shared types, constants and character helpers for the text-to-integer parser.
`timescale 1ns / 1ps
`default_nettype none

package ttui_pkg;

	// Field widths of the streams and of the configuration register.
	localparam int CHAR_W   = 8;
	localparam int BASE_W   = 6;
	localparam int VALUE_W  = 64;
	localparam int OFFSET_W = 13;
	localparam int STATUS_W = 2;

	// Default saturation point of the character position counters.
	localparam int MAX_CHARS_DEFAULT = 4096;

	// Radix codes used by the parser.
	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_BAD  = 6'd1;
	localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

	// Digit value reported for a character that is no digit in any radix.
	localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd36;

	// Characters with a meaning of their own.
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// One finished conversion before the sign is applied.
	typedef struct packed {
		logic [VALUE_W-1:0]  acc;
		logic                neg;
		logic [OFFSET_W-1:0] offset;
		status_t             status;
	} ttui_result_t;

	// Value of a character as a digit, DIGIT_NONE when it is none.
	function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [BASE_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = BASE_W'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = BASE_W'(c - CH_LA) + BASE_DEC;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = BASE_W'(c - CH_UA) + BASE_DEC;
		end
		return d;
	endfunction

	// Space, or tab through carriage return.
	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

### rtl/ttui_char_if.sv
// Character stream channel: one byte of text and an end-of-string mark per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface ttui_char_if;
	import ttui_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

### rtl/ttui_result_if.sv
// Result channel: converted value, end offset and status per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface ttui_result_if;
	import ttui_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [OFFSET_W-1:0] end_offset;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output value, output end_offset, output status,
		input ready);
	modport sink (input valid, input value, input end_offset, input status,
		output ready);
endinterface

`default_nettype wire

### rtl/text_to_unsigned_integer_parser.sv
// Top level of the streaming text-to-unsigned-integer parser.
//
//   channel  role    transfer when        payload
//   chars    sink    valid && ready       char_code[7:0], is_last
//   results  source  valid && ready       value[63:0], end_offset[12:0], status[1:0]
//   cfg      write   cfg_wr_en            cfg_wr_data[5:0] -> base_select
//
// One character is taken in every clock cycle unless a closing character waits
// in the input register behind a stalled result. A character passes an input
// register, then updates the parse state with one 64 by 6 bit multiply-add; a
// string's result is written to the output register on that same edge.
// The output register frees its slot in the cycle it is read, so a stalled
// result only holds back the character that would produce the next result.
// Reset is asynchronous and active low; it clears base_select to auto mode.
`timescale 1ns / 1ps
`default_nettype none

module text_to_unsigned_integer_parser #(
	parameter int MAX_CHARS = ttui_pkg::MAX_CHARS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ttui_char_if.sink                        chars,
	ttui_result_if.source                    results,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ttui_pkg::BASE_W-1:0] cfg_wr_data
);
	import ttui_pkg::*;

	// Configuration: the radix selection, sampled by the core at the start
	// of every string.
	logic [BASE_W-1:0] base_select_q;

	// Input register stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// Output register.
	logic                res_valid_q;
	logic [VALUE_W-1:0]  res_acc_q;
	logic                res_neg_q;
	logic [OFFSET_W-1:0] res_offset_q;
	status_t             res_status_q;

	logic         emit_s1;
	logic         out_free;
	logic         advance;
	ttui_result_t res_s1;

	// A character that ends a string needs the output slot; any other one
	// moves on regardless of the result side.
	assign out_free     = !res_valid_q || results.ready;
	assign advance      = valid_s1 && (!emit_s1 || out_free);
	assign chars.ready  = !valid_s1 || advance;

	ttui_core #(
		.MAX_CHARS(MAX_CHARS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.char_code  (char_s1),
		.is_last    (last_s1),
		.base_select(base_select_q),
		.emit       (emit_s1),
		.res        (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_select_q <= BASE_AUTO;
		end else if (cfg_wr_en) begin
			base_select_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_s1) begin
			res_acc_q    <= res_s1.acc;
			res_neg_q    <= res_s1.neg;
			res_offset_q <= res_s1.offset;
			res_status_q <= res_s1.status;
		end
	end

	// The minus sign is applied after the output register, which keeps the
	// negation out of the multiply-add path.
	assign results.valid      = res_valid_q;
	assign results.value      = res_neg_q ? VALUE_W'(0) - res_acc_q : res_acc_q;
	assign results.end_offset = res_offset_q;
	assign results.status     = res_status_q;

	// An out-of-range result always reads as all ones.
	a_range_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == ST_RANGE |-> results.value == '1)
		else $error("range status without saturated value");

	// An error or an empty conversion carries neither a value nor an offset.
	a_no_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == ST_INVALID || res_offset_q == '0)
		|-> results.value == '0 && results.end_offset == '0)
		else $error("nonzero value without converted characters");

	// A character held back in the input stage keeps its contents.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled character lost");

	// A result is never written over before it is read.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit_s1 |-> !res_valid_q || results.ready)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### rtl/ttui_core.sv
// Parse state machine with the per-character multiply-add of the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module ttui_core #(
	parameter int MAX_CHARS = ttui_pkg::MAX_CHARS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [ttui_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                         is_last,
	input  wire logic [ttui_pkg::BASE_W-1:0]  base_select,
	output      logic                         emit,
	output      ttui_pkg::ttui_result_t       res
);
	import ttui_pkg::*;

	localparam int POS_W = $clog2(MAX_CHARS + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_ZEROX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic               neg_q, neg_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic               ovf_q, ovf_n;
	logic [BASE_W-1:0]  base_q, base_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [POS_W-1:0]   endp_q, endp_n;
	logic               sign_q, sign_n;

	logic [POS_W-1:0]   pos_inc;
	logic [BASE_W-1:0]  digit;
	logic               first;

	assign pos_inc = (pos_q >= POS_MAX) ? POS_MAX : pos_q + 1'b1;
	assign digit   = digit_of(char_code);
	assign first   = (pos_q == '0) && (phase_q == PH_SPACE);
	assign emit    = (char_code == CH_NUL) || is_last;

	always_comb begin
		logic [BASE_W-1:0]      b0;
		logic [BASE_W-1:0]      tb;
		logic                   take;
		logic [VALUE_W+BASE_W-1:0] prod;

		b0      = first ? base_select : base_q;
		tb      = b0;
		take    = 1'b0;
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		ovf_n   = ovf_q;
		base_n  = b0;
		pos_n   = pos_q;
		endp_n  = endp_q;
		sign_n  = sign_q;

		if (char_code != CH_NUL) begin
			pos_n = pos_inc;
			unique case (phase_q)
				PH_SPACE, PH_SIGNED: begin
					if (phase_q == PH_SIGNED || !is_blank(char_code)) begin
						if (b0 == BASE_BAD || b0 > BASE_MAX) begin
							phase_n = PH_DONE;
						end else if (phase_q == PH_SPACE &&
							(char_code == CH_PLUS || char_code == CH_MINUS)) begin
							sign_n  = 1'b1;
							neg_n   = (char_code == CH_MINUS);
							phase_n = PH_SIGNED;
						end else if ((b0 == BASE_AUTO || b0 == BASE_HEX) &&
							char_code == CH_ZERO) begin
							acc_n   = '0;
							endp_n  = pos_inc;
							phase_n = PH_ZERO;
						end else begin
							tb     = (b0 == BASE_AUTO) ? BASE_DEC : b0;
							base_n = tb;
							take   = 1'b1;
						end
					end
				end
				PH_ZERO: begin
					if (char_code == CH_LX || char_code == CH_UX) begin
						phase_n = PH_ZEROX;
					end else begin
						tb     = (b0 == BASE_AUTO) ? BASE_OCT : b0;
						base_n = tb;
						take   = 1'b1;
					end
				end
				PH_ZEROX: begin
					if (digit < BASE_HEX) begin
						tb     = BASE_HEX;
						base_n = BASE_HEX;
						take   = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					take = 1'b1;
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase
		end

		// One multiply-add per character; any bit above the low 64 means overflow.
		prod = (VALUE_W+BASE_W)'(acc_q) * (VALUE_W+BASE_W)'(tb) +
			(VALUE_W+BASE_W)'(digit);
		if (take) begin
			if (tb < BASE_MIN || tb > BASE_MAX || digit >= tb) begin
				phase_n = PH_DONE;
			end else begin
				if (!ovf_q) begin
					ovf_n = |prod[VALUE_W+BASE_W-1:VALUE_W];
					acc_n = prod[VALUE_W-1:0];
				end
				endp_n  = pos_inc;
				phase_n = PH_DIGITS;
			end
		end
	end

	always_comb begin
		res.acc    = '0;
		res.neg    = 1'b0;
		res.offset = '0;
		res.status = ST_OK;
		if (base_n == BASE_BAD || base_n > BASE_MAX) begin
			res.status = ST_INVALID;
		end else if (endp_n == '0) begin
			res.status = sign_n ? ST_INVALID : ST_OK;
		end else if (ovf_n) begin
			res.acc    = '1;
			res.offset = OFFSET_W'(endp_n);
			res.status = ST_RANGE;
		end else begin
			res.acc    = acc_n;
			res.neg    = neg_n;
			res.offset = OFFSET_W'(endp_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			base_q  <= '0;
			pos_q   <= '0;
			endp_q  <= '0;
			sign_q  <= 1'b0;
		end else if (advance) begin
			if (emit) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				base_q  <= '0;
				pos_q   <= '0;
				endp_q  <= '0;
				sign_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				base_q  <= base_n;
				pos_q   <= pos_n;
				endp_q  <= endp_n;
				sign_q  <= sign_n;
			end
		end
	end

	// A finished string leaves the parser ready for a fresh one.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> pos_q == '0 && phase_q == PH_SPACE && !ovf_q)
		else $error("parser state not cleared after a result");

	// The end of the last digit never lies beyond the characters consumed.
	a_end_within_pos: assert property (@(posedge clk) disable iff (!arst_n)
		endp_q <= pos_q && pos_q <= POS_MAX)
		else $error("end position beyond consumed characters");

endmodule

`default_nettype wire
